// ===== hw/rtl/fixed_timestep_frame_clock_defines.svh =====
//----------------------------------------------------------------------------
// Frame clock assertion macros
// Shared property wrappers for the frame clock checks, clocked on clk and
// quiet while arst_n is low.
//----------------------------------------------------------------------------
`ifndef FIXED_TIMESTEP_FRAME_CLOCK_DEFINES_SVH
`define FIXED_TIMESTEP_FRAME_CLOCK_DEFINES_SVH

// same-cycle implication
`define FTFC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame clock check failed");

// next-cycle implication
`define FTFC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame clock check failed");

`endif

// ===== hw/rtl/ftfc_pkg.sv =====
//----------------------------------------------------------------------------
// Frame clock package
// Widths, reset values, register indexes and the shared unit's op codes.
//----------------------------------------------------------------------------
package ftfc_pkg;

	localparam int TIME_BITS_DEF  = 24;
	localparam int COUNT_BITS_DEF = 16;

	localparam int SCALE_BITS  = 16;
	localparam int SCALE_FRAC  = 8;
	localparam int ALPHA_BITS  = 16;
	localparam int DELTA_BITS  = 32;
	localparam int TOTAL_BITS  = 48;

	localparam int TARGET_RST  = 0;
	localparam int MAX_FT_RST  = 250000;
	localparam int SCALE_RST   = 256;
	localparam int STEP_RST    = 11111;

	localparam int CFG_IDX_BITS = 2;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_TARGET_FRAME = 2'd0;
	localparam cfg_idx_t CFG_MAX_FRAME    = 2'd1;
	localparam cfg_idx_t CFG_TIME_SCALE   = 2'd2;
	localparam cfg_idx_t CFG_FIXED_STEP   = 2'd3;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

endpackage

// ===== hw/rtl/ftfc_regs.sv =====
//----------------------------------------------------------------------------
// Frame clock configuration registers
// Four write-only registers loaded from the plain write port.
//----------------------------------------------------------------------------
module ftfc_regs #(
	parameter int TIME_BITS = ftfc_pkg::TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  ftfc_pkg::cfg_idx_t           cfg_index,
	input  logic [TIME_BITS-1:0]         cfg_data,
	output logic [TIME_BITS-1:0]         target_frame_time,
	output logic [TIME_BITS-1:0]         max_frame_time,
	output logic [ftfc_pkg::SCALE_BITS-1:0] time_scale,
	output logic [TIME_BITS-1:0]         fixed_step
);
	import ftfc_pkg::*;

	logic [TIME_BITS-1:0]  target_q;
	logic [TIME_BITS-1:0]  max_ft_q;
	logic [SCALE_BITS-1:0] scale_q;
	logic [TIME_BITS-1:0]  step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TIME_BITS'(TARGET_RST);
			max_ft_q <= TIME_BITS'(MAX_FT_RST);
			scale_q  <= SCALE_BITS'(SCALE_RST);
			step_q   <= TIME_BITS'(STEP_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TARGET_FRAME: target_q <= cfg_data;
				CFG_MAX_FRAME:    max_ft_q <= cfg_data;
				CFG_TIME_SCALE:   scale_q  <= cfg_data[SCALE_BITS-1:0];
				CFG_FIXED_STEP:   step_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign target_frame_time = target_q;
	assign max_frame_time    = max_ft_q;
	assign time_scale        = scale_q;
	assign fixed_step        = step_q;

endmodule

// ===== hw/rtl/ftfc_alu.sv =====
//----------------------------------------------------------------------------
// Frame clock shared adder
// One add/sub unit with borrow out for gather, limit, clamp, acc and div.
//----------------------------------------------------------------------------
module ftfc_alu #(
	parameter int WIDTH = ftfc_pkg::TIME_BITS_DEF + 9
) (
	input  ftfc_pkg::alu_op_t op,
	input  logic [WIDTH-1:0]  a,
	input  logic [WIDTH-1:0]  b,
	output logic [WIDTH-1:0]  res,
	output logic              borrow
);
	import ftfc_pkg::*;

	logic [WIDTH:0] full;

	always_comb begin
		case (op)
			ALU_ADD: full = {1'b0, a} + {1'b0, b};
			ALU_SUB: full = {1'b0, a} - {1'b0, b};
			default: full = {1'b0, a} + {1'b0, b};
		endcase
	end

	assign res    = full[WIDTH-1:0];
	// a below b on a subtract
	assign borrow = (op == ALU_SUB) && full[WIDTH];

endmodule

// ===== hw/rtl/fixed_timestep_frame_clock.sv =====
//----------------------------------------------------------------------------
// Fixed timestep frame clock
// Frame limiter, clamp, time scale and fixed-step split over one shared unit.
//----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, elapsed_time) takes one tick word per
//   frame. Every tick yields exactly one result word on the output channel
//   (out_valid/out_ready): can_update, delta_time, step_count, alpha and
//   total_time. Registers are written through cfg_we/cfg_index/cfg_data
//   while the block is idle.
//   A released frame runs gather, limit (both only with the limiter on),
//   clamp, multiply and accumulate steps, then a long division of one bit
//   per cycle over TIME_BITS+25 bits (quotient, then 16 alpha bits) on the
//   shared subtractor. A held frame goes from the limit step straight to
//   the last step. in_ready is high only while idle, so a new tick is not
//   taken until the last one has left the last step.
//   The result sits in an output register; a new tick is accepted while
//   it waits, and the next result holds in the last step until out_ready
//   frees the register.
//   Reset clears the gather, remainder and total state and loads the
//   register defaults (limiter off, 250000 us clamp, unity scale, 11111 us
//   fixed step).
//----------------------------------------------------------------------------
module fixed_timestep_frame_clock #(
	parameter int TIME_BITS  = ftfc_pkg::TIME_BITS_DEF,
	parameter int COUNT_BITS = ftfc_pkg::COUNT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  ftfc_pkg::cfg_idx_t                 cfg_index,
	input  logic [TIME_BITS-1:0]               cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [TIME_BITS-1:0]               elapsed_time,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               can_update,
	output logic [ftfc_pkg::DELTA_BITS-1:0]    delta_time,
	output logic [COUNT_BITS-1:0]              step_count,
	output logic [ftfc_pkg::ALPHA_BITS-1:0]    alpha,
	output logic [ftfc_pkg::TOTAL_BITS-1:0]    total_time
);
	import ftfc_pkg::*;

	`include "fixed_timestep_frame_clock_defines.svh"

	localparam int SW = TIME_BITS + SCALE_BITS - SCALE_FRAC;  // scaled delta
	localparam int QW = SW + 1;                               // accumulator
	localparam int AW = QW;                                   // shared unit
	localparam int DW = QW + ALPHA_BITS;                      // dividend
	localparam int CW = $clog2(DW);
	localparam int PW = TIME_BITS + SCALE_BITS;
	localparam int XW = (SW > DELTA_BITS) ? SW : DELTA_BITS;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_GATHER = 8'b0000_0010,
		S_LIMIT  = 8'b0000_0100,
		S_CLAMP  = 8'b0000_1000,
		S_MUL    = 8'b0001_0000,
		S_ACC    = 8'b0010_0000,
		S_DIV    = 8'b0100_0000,
		S_FINISH = 8'b1000_0000
	} state_t;

	logic [TIME_BITS-1:0]  target_frame_time;
	logic [TIME_BITS-1:0]  max_frame_time;
	logic [SCALE_BITS-1:0] time_scale;
	logic [TIME_BITS-1:0]  fixed_step;

	state_t                state_q;
	logic [TIME_BITS:0]    gather_q;
	logic [TIME_BITS-1:0]  rem_q;
	logic [TOTAL_BITS-1:0] total_q;

	logic [TIME_BITS:0]    raw_q;
	logic [SW-1:0]         scaled_q;
	logic [DW-1:0]         dvd_q;
	logic [TIME_BITS-1:0]  part_q;
	logic [CW-1:0]         cnt_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  ovf_q;
	logic [ALPHA_BITS-1:0] alpha_q;
	logic                  zero_q;

	logic                  out_valid_q;
	logic                  can_update_q;
	logic [DELTA_BITS-1:0] delta_q;
	logic [COUNT_BITS-1:0] step_count_q;
	logic [ALPHA_BITS-1:0] alpha_out_q;
	logic [TOTAL_BITS-1:0] total_out_q;

	alu_op_t               alu_op;
	logic [AW-1:0]         alu_a;
	logic [AW-1:0]         alu_b;
	logic [AW-1:0]         alu_res;
	logic                  alu_borrow;

	logic [TIME_BITS:0]    trial;
	logic [TIME_BITS-1:0]  next_part;
	logic [PW-1:0]         prod;
	logic [XW-1:0]         scaled_x;
	logic [DELTA_BITS-1:0] delta_sat;

	ftfc_regs #(
		.TIME_BITS(TIME_BITS)
	) u_regs (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.target_frame_time(target_frame_time),
		.max_frame_time   (max_frame_time),
		.time_scale       (time_scale),
		.fixed_step       (fixed_step)
	);

	ftfc_alu #(
		.WIDTH(AW)
	) u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.res   (alu_res),
		.borrow(alu_borrow)
	);

	assign trial     = {part_q, dvd_q[DW-1]};
	assign next_part = alu_borrow ? trial[TIME_BITS-1:0] : alu_res[TIME_BITS-1:0];
	assign prod      = PW'(raw_q[TIME_BITS-1:0]) * PW'(time_scale);
	assign scaled_x  = XW'(scaled_q);
	assign delta_sat = (scaled_x > XW'({DELTA_BITS{1'b1}})) ? {DELTA_BITS{1'b1}}
	                                                        : scaled_x[DELTA_BITS-1:0];

	// operand select for the shared unit
	always_comb begin
		alu_op = ALU_SUB;
		alu_a  = AW'(raw_q);
		alu_b  = AW'(max_frame_time);
		case (state_q)
			S_GATHER: begin
				alu_op = ALU_ADD;
				alu_a  = AW'(gather_q);
				alu_b  = AW'(raw_q);
			end
			S_LIMIT: begin
				alu_a = AW'(raw_q);
				alu_b = AW'(target_frame_time);
			end
			S_ACC: begin
				alu_op = ALU_ADD;
				alu_a  = AW'(rem_q);
				alu_b  = AW'(scaled_q);
			end
			S_DIV: begin
				alu_a = AW'(trial);
				alu_b = AW'(fixed_step);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			gather_q    <= '0;
			rem_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// the last step reloads the word itself
			if (out_valid_q && out_ready && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						raw_q  <= {1'b0, elapsed_time};
						zero_q <= 1'b0;
						state_q <= (target_frame_time != '0) ? S_GATHER : S_CLAMP;
					end
				end
				S_GATHER: begin
					raw_q   <= alu_res[TIME_BITS:0];
					state_q <= S_LIMIT;
				end
				S_LIMIT: begin
					if (alu_borrow) begin
						// hold the frame back and keep gathering
						gather_q <= raw_q;
						zero_q   <= 1'b1;
						state_q  <= S_FINISH;
					end else begin
						gather_q <= '0;
						state_q  <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					if (!alu_borrow) begin
						raw_q <= {1'b0, max_frame_time};
					end
					state_q <= S_MUL;
				end
				S_MUL: begin
					scaled_q <= prod[PW-1:SCALE_FRAC];
					state_q  <= S_ACC;
				end
				S_ACC: begin
					total_q <= total_q + TOTAL_BITS'(scaled_q);
					dvd_q   <= {alu_res, {ALPHA_BITS{1'b0}}};
					part_q  <= '0;
					cnt_q   <= '0;
					ovf_q   <= 1'b0;
					alpha_q <= '0;
					if (fixed_step == '0) begin
						count_q <= '1;
						rem_q   <= '0;
						state_q <= S_FINISH;
					end else begin
						count_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					part_q <= next_part;
					dvd_q  <= {dvd_q[DW-2:0], 1'b0};
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q < CW'(QW)) begin
						count_q <= {count_q[COUNT_BITS-2:0], !alu_borrow};
						ovf_q   <= ovf_q | count_q[COUNT_BITS-1];
					end else begin
						alpha_q <= {alpha_q[ALPHA_BITS-2:0], !alu_borrow};
					end
					if (cnt_q == CW'(QW - 1)) begin
						rem_q <= next_part;
					end
					if (cnt_q == CW'(DW - 1)) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					// wait until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && (!out_valid_q || out_ready)) begin
			if (zero_q) begin
				can_update_q <= 1'b0;
				delta_q      <= '0;
				step_count_q <= '0;
				alpha_out_q  <= '0;
				total_out_q  <= '0;
			end else begin
				can_update_q <= 1'b1;
				delta_q      <= delta_sat;
				step_count_q <= ovf_q ? {COUNT_BITS{1'b1}} : count_q;
				alpha_out_q  <= alpha_q;
				total_out_q  <= total_q;
			end
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign can_update = can_update_q;
	assign delta_time = delta_q;
	assign step_count = step_count_q;
	assign alpha      = alpha_out_q;
	assign total_time = total_out_q;

	`FTFC_ASSERT_IMPL(a_part_below_step, state_q == S_DIV, part_q < fixed_step)
	`FTFC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`FTFC_ASSERT_IMPL(a_result_from_finish, $rose(out_valid_q), $past(state_q == S_FINISH))
	`FTFC_ASSERT_IMPL(a_held_frame_zero, out_valid_q && !can_update_q,
		delta_q == '0 && step_count_q == '0 && alpha_out_q == '0 && total_out_q == '0)

endmodule
